### design/ccb_pkg.sv
// ----------------------------------------------------------------------------
// ccb_pkg: shared types and constants
// Beat formats, register indexes and limits for the conservative counting
// Bloom filter.
// ----------------------------------------------------------------------------
package ccb_pkg;

  localparam int unsigned DEF_MAX_BUCKETS = 65536;
  localparam int unsigned DEF_MAX_HASHES  = 32;

  localparam int unsigned HC_W = 6;
  localparam int unsigned BC_W = 17;

  localparam logic [7:0]      COUNTER_MAX      = 8'd255;
  localparam logic [HC_W-1:0] HASH_COUNT_RST   = 6'd4;
  localparam logic [BC_W-1:0] BUCKET_COUNT_RST = 17'd65536;

  typedef enum logic {
    REG_HASH_COUNT   = 1'b0,
    REG_BUCKET_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key_hash_a;
    logic [63:0] key_hash_b;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  min_count;
    logic        present;
    logic [63:0] keys_added;
  } out_beat_t;

  // Job header handed from the front to the back.
  typedef struct packed {
    logic            is_query;
    logic [63:0]     hash_a;
    logic [63:0]     hash_b;
    logic [HC_W-1:0] probes;
  } ccb_job_t;

endpackage

### design/ccb_front.sv
// ----------------------------------------------------------------------------
// ccb_front: request intake and residue unit
// Accepts a request, then reduces both hashes and 2^64 modulo the bucket
// count, one bit per cycle, and hands the job to the queue.
// ----------------------------------------------------------------------------
module ccb_front
  import ccb_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int unsigned MAX_HASHES  = DEF_MAX_HASHES,
  localparam int unsigned NBW = $clog2(MAX_BUCKETS) + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_beat_t          in_data,
  input  logic [HC_W-1:0]   hash_count,
  input  logic [BC_W-1:0]   bucket_count,
  output logic              busy,
  output logic              job_valid,
  input  logic              job_ready,
  output ccb_job_t          job_hdr,
  output logic [4*NBW-1:0]  job_res
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t        state_r;
  logic [5:0]     cnt_r;
  logic [63:0]    xa_r, xb_r;
  logic [NBW-1:0] ra_r, rb_r, rc_r, nb_r;
  ccb_job_t       hdr_r;
  logic [NBW-1:0] nb_nxt;
  logic [HC_W-1:0] np_nxt;
  logic [NBW:0]   r64_inc;
  logic [NBW-1:0] r64;

  function automatic logic [NBW-1:0] mstep(input logic [NBW-1:0] r, input logic b,
                                           input logic [NBW-1:0] d);
    logic [NBW:0] sh;
    sh = {r, b};
    if (sh >= {1'b0, d}) sh = sh - {1'b0, d};
    return sh[NBW-1:0];
  endfunction

  always_comb begin
    if (bucket_count == '0) begin
      nb_nxt = NBW'(1);
    end else if (32'(bucket_count) > MAX_BUCKETS) begin
      nb_nxt = NBW'(MAX_BUCKETS);
    end else begin
      nb_nxt = NBW'(bucket_count);
    end
    if (32'(hash_count) > MAX_HASHES) begin
      np_nxt = HC_W'(MAX_HASHES);
    end else begin
      np_nxt = hash_count;
    end
  end

  // 2^64 mod n is one more than (2^64 - 1) mod n, wrapped.
  assign r64_inc = {1'b0, rc_r} + (NBW+1)'(1);
  assign r64     = (r64_inc == {1'b0, nb_r}) ? '0 : r64_inc[NBW-1:0];

  assign busy      = (state_r != F_IDLE);
  assign job_valid = (state_r == F_PUSH);
  assign job_hdr   = hdr_r;
  assign job_res   = {ra_r, rb_r, r64, nb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            hdr_r.is_query <= in_data.req_type;
            hdr_r.hash_a   <= in_data.key_hash_a;
            hdr_r.hash_b   <= in_data.key_hash_b;
            hdr_r.probes   <= np_nxt;
            xa_r    <= in_data.key_hash_a;
            xb_r    <= in_data.key_hash_b;
            nb_r    <= nb_nxt;
            ra_r    <= '0;
            rb_r    <= '0;
            rc_r    <= '0;
            cnt_r   <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          ra_r  <= mstep(ra_r, xa_r[63], nb_r);
          rb_r  <= mstep(rb_r, xb_r[63], nb_r);
          rc_r  <= mstep(rc_r, 1'b1, nb_r);
          xa_r  <= {xa_r[62:0], 1'b0};
          xb_r  <= {xb_r[62:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

### design/ccb_queue.sv
// ----------------------------------------------------------------------------
// ccb_queue: two-entry job queue
// Decouples the residue front from the counter table back.
// ----------------------------------------------------------------------------
module ccb_queue
  import ccb_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         nonempty
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/ccb_back.sv
// ----------------------------------------------------------------------------
// ccb_back: counter table engine
// Clears the table after reset, then walks the probe sequence of each job:
// a minimum pass and, for adds whose minimum is below COUNTER_MAX, a conservative increment pass.
// ----------------------------------------------------------------------------
module ccb_back
  import ccb_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = DEF_MAX_BUCKETS,
  localparam int unsigned AW  = $clog2(MAX_BUCKETS),
  localparam int unsigned NBW = AW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_pop,
  input  ccb_job_t         job_hdr,
  input  logic [4*NBW-1:0] job_res,
  output logic             clearing,
  output logic             out_valid,
  output out_beat_t        out_data
);

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_ADV, B_RD, B_CHK, B_FIN} bstate_t;

  logic [7:0] mem [MAX_BUCKETS];

  bstate_t         state_r;
  logic [AW-1:0]   clr_r;
  ccb_job_t        hdr_r;
  logic [NBW-1:0]  ra_r, rb_r, r64_r, nb_r, res_r;
  logic [63:0]     pos_r, total_r;
  logic [HC_W-1:0] cnt_r;
  logic [7:0]      min_r, rdata_r, min_nxt;
  logic            pass2_r, out_valid_r, last;
  out_beat_t       out_data_r;
  logic [64:0]     sum;
  logic [NBW:0]    t, u;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;

  // Next probe residue, tracking the 2^64 wrap of the position.
  always_comb begin
    sum = {1'b0, pos_r} + {1'b0, hdr_r.hash_b};
    t   = {1'b0, res_r} + {1'b0, rb_r};
    if (t >= {1'b0, nb_r}) t = t - {1'b0, nb_r};
    u = t;
    if (sum[64]) begin
      if (t >= {1'b0, r64_r}) u = t - {1'b0, r64_r};
      else                    u = t + {1'b0, nb_r} - {1'b0, r64_r};
    end
  end

  assign min_nxt = (rdata_r < min_r) ? rdata_r : min_r;
  assign last    = (cnt_r == hdr_r.probes - HC_W'(1));

  always_comb begin
    we    = 1'b0;
    waddr = res_r[AW-1:0];
    wdata = min_r + 8'd1;
    if (state_r == B_CLR) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (state_r == B_CHK && pass2_r && rdata_r == min_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[res_r[AW-1:0]];
  end

  assign job_pop   = (state_r == B_IDLE) && job_valid;
  assign clearing  = (state_r == B_CLR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAX_BUCKETS - 1)) state_r <= B_IDLE;
        end
        B_IDLE: begin
          if (job_valid) begin
            hdr_r   <= job_hdr;
            {ra_r, rb_r, r64_r, nb_r} <= job_res;
            res_r   <= job_res[4*NBW-1:3*NBW];
            pos_r   <= job_hdr.hash_a;
            cnt_r   <= '0;
            min_r   <= COUNTER_MAX;
            pass2_r <= 1'b0;
            state_r <= (job_hdr.probes == '0) ? B_FIN : B_ADV;
          end
        end
        B_ADV: begin
          pos_r   <= sum[63:0];
          res_r   <= u[NBW-1:0];
          state_r <= B_RD;
        end
        B_RD: state_r <= B_CHK;
        B_CHK: begin
          if (!pass2_r) begin
            min_r <= min_nxt;
            if (last) begin
              if (!hdr_r.is_query && min_nxt != COUNTER_MAX) begin
                pass2_r <= 1'b1;
                pos_r   <= hdr_r.hash_a;
                res_r   <= ra_r;
                cnt_r   <= '0;
                state_r <= B_ADV;
              end else begin
                state_r <= B_FIN;
              end
            end else begin
              cnt_r   <= cnt_r + HC_W'(1);
              state_r <= B_ADV;
            end
          end else if (last) begin
            state_r <= B_FIN;
          end else begin
            cnt_r   <= cnt_r + HC_W'(1);
            state_r <= B_ADV;
          end
        end
        B_FIN: begin
          out_valid_r          <= 1'b1;
          out_data_r.min_count <= min_r;
          out_data_r.present   <= (min_r != 8'd0);
          if (hdr_r.is_query) begin
            out_data_r.keys_added <= total_r;
          end else begin
            out_data_r.keys_added <= total_r + 64'd1;
            total_r               <= total_r + 64'd1;
          end
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### design/conservative_counting_bloom.sv
// ----------------------------------------------------------------------------
// conservative_counting_bloom: conservative-update counting Bloom filter
// Table of 8-bit counters probed by double hashing of two 64-bit key hashes.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (add or query, two key hashes) is taken when start is high
// and busy is low. Exactly one result beat follows on out_data, marked by a
// one-cycle out_valid strobe; the receiver cannot stall it.
// The front reduces both hashes and 2^64 modulo the bucket count one bit per
// cycle. The back then steps each probe of each pass through the advance,
// read and check states on the counter table: a query makes one pass over
// the H probes and an add up to two, with H the probe count. A two-entry job
// queue lets the front take the next request while the back works; the front
// stays busy for each request through its residue and push states, until the
// job enters the queue. After reset the table is cleared one counter per
// cycle, all MAX_BUCKETS of them, while busy stays high; registers may be
// written over APB meanwhile. Registers: hash_count at byte 0, bucket_count
// at byte 4; the user must write them only idle; the block does not check.
// ----------------------------------------------------------------------------
module conservative_counting_bloom
  import ccb_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int unsigned MAX_HASHES  = DEF_MAX_HASHES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_beat_t    in_data,
  output logic        out_valid,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NBW = $clog2(MAX_BUCKETS) + 1;
  localparam int unsigned JW  = $bits(ccb_job_t) + 4 * NBW;

  logic [HC_W-1:0]  hash_count_r;
  logic [BC_W-1:0]  bucket_count_r;
  logic             accept, front_busy, clearing;
  logic             job_valid, q_full, q_nonempty, job_pop;
  ccb_job_t         job_hdr, q_hdr;
  logic [4*NBW-1:0] job_res, q_res;
  logic             wr_en;
  reg_idx_t         wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_count_r   <= HASH_COUNT_RST;
      bucket_count_r <= BUCKET_COUNT_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_HASH_COUNT:   hash_count_r   <= pwdata[HC_W-1:0];
        REG_BUCKET_COUNT: bucket_count_r <= pwdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_HASH_COUNT:   prdata = 32'(hash_count_r);
      REG_BUCKET_COUNT: prdata = 32'(bucket_count_r);
      default:          prdata = '0;
    endcase
  end

  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  ccb_front #(.MAX_BUCKETS(MAX_BUCKETS), .MAX_HASHES(MAX_HASHES)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .in_data(in_data),
    .hash_count(hash_count_r), .bucket_count(bucket_count_r),
    .busy(front_busy), .job_valid(job_valid), .job_ready(!q_full),
    .job_hdr(job_hdr), .job_res(job_res)
  );

  ccb_queue #(.W(JW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(job_valid && !q_full), .push_data({job_hdr, job_res}), .full(q_full),
    .pop(job_pop), .pop_data({q_hdr, q_res}), .nonempty(q_nonempty)
  );

  ccb_back #(.MAX_BUCKETS(MAX_BUCKETS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_nonempty), .job_pop(job_pop),
    .job_hdr(q_hdr), .job_res(q_res), .clearing(clearing),
    .out_valid(out_valid), .out_data(out_data)
  );

  a_present_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.present == (out_data.min_count != 8'd0)))
    else $error("present flag disagrees with minimum");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid && !job_pop)
    else $error("table activity during clearing pass");

  a_busy_after_reset: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> busy)
    else $error("request possible before table is cleared");

endmodule
